>>> rtl/core/lgs_pkg.sv
`timescale 1ns / 1ps
package lgs_pkg;

   localparam int COLS_WIDTH = 12;
   localparam int ROWS_WIDTH = 11;

   localparam logic [COLS_WIDTH-1:0] COLS_RESET = 12'd1599;
   localparam logic [ROWS_WIDTH-1:0] ROWS_RESET = 11'd959;

   localparam logic CSR_COLS = 1'b0;
   localparam logic CSR_ROWS = 1'b1;

   localparam logic [3:0] BIRTH_COUNT = 4'd3;
   localparam logic [3:0] SURVIVE_MIN = 4'd2;
   localparam logic [3:0] SURVIVE_MAX = 4'd3;

   localparam int OUT_DEPTH = 4;
   localparam int OUT_PTR_WIDTH = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_WIDTH = $clog2(OUT_DEPTH + 1);

   typedef struct packed {
      logic valid;
      logic alive;
      logic produce;
      logic last;
   } stage_type;

   typedef struct packed {
      logic next_alive;
      logic last_cell;
   } result_type;

endpackage

>>> rtl/core/lgs_ram.sv
`timescale 1ns / 1ps
module lgs_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 2050
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/lgs_scan.sv
`timescale 1ns / 1ps
module lgs_scan
   import lgs_pkg::*;
#(
   parameter int MAX_COLS = 2048,
   parameter int MAX_ROWS = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic                              csr_index,
   input  logic [COLS_WIDTH-1:0]             csr_write_data,
   input  logic                              accept,
   input  logic                              cell_alive,
   output logic [$clog2(MAX_COLS+2)-1:0]     rd_addr,
   output stage_type                         stage,
   output logic [$clog2(MAX_COLS+2)-1:0]     stage_idx
);

   localparam int CW = $clog2(MAX_COLS + 2);
   localparam int RW = $clog2(MAX_ROWS + 2);
   localparam int CXW = (CW > COLS_WIDTH) ? CW : COLS_WIDTH;
   localparam int RXW = (RW > ROWS_WIDTH) ? RW : ROWS_WIDTH;

   logic [COLS_WIDTH-1:0] cols_ff;
   logic [ROWS_WIDTH-1:0] rows_ff;
   logic [CW-1:0]         col_count_ff, col_count_in;
   logic [RW-1:0]         row_count_ff, row_count_in;
   stage_type             stage_ff, stage_in;
   logic [CW-1:0]         stage_idx_ff;

   logic [CXW-1:0] cols_ext, nc_wide;
   logic [RXW-1:0] rows_ext, nr_wide;
   logic [CW-1:0]  nc1;
   logic [RW-1:0]  nr1;
   logic           frame;

   always_comb begin
      cols_ext = CXW'(cols_ff);
      rows_ext = RXW'(rows_ff);
      if (cols_ext == '0) begin
         nc_wide = CXW'(1);
      end else if (cols_ext > CXW'(MAX_COLS)) begin
         nc_wide = CXW'(MAX_COLS);
      end else begin
         nc_wide = cols_ext;
      end
      if (rows_ext == '0) begin
         nr_wide = RXW'(1);
      end else if (rows_ext > RXW'(MAX_ROWS)) begin
         nr_wide = RXW'(MAX_ROWS);
      end else begin
         nr_wide = rows_ext;
      end
      nc1 = CW'(nc_wide) + CW'(1);
      nr1 = RW'(nr_wide) + RW'(1);

      frame = (col_count_ff == '0) || (row_count_ff == '0) ||
              (col_count_ff >= nc1) || (row_count_ff >= nr1);

      stage_in.valid   = accept;
      stage_in.alive   = cell_alive & ~frame;
      stage_in.produce = (col_count_ff >= CW'(2)) && (row_count_ff >= RW'(2)) &&
                         (col_count_ff <= nc1) && (row_count_ff <= nr1);
      stage_in.last    = (col_count_ff == nc1) && (row_count_ff == nr1);

      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (accept) begin
         if (col_count_ff >= nc1) begin
            col_count_in = '0;
            row_count_in = (row_count_ff >= nr1) ? '0 : row_count_ff + RW'(1);
         end else begin
            col_count_in = col_count_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff      <= COLS_RESET;
         rows_ff      <= ROWS_RESET;
         col_count_ff <= '0;
         row_count_ff <= '0;
         stage_ff     <= '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_COLS: cols_ff <= csr_write_data;
               CSR_ROWS: rows_ff <= csr_write_data[ROWS_WIDTH-1:0];
               default: ;
            endcase
         end
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
         stage_ff     <= stage_in;
      end
      if (accept) begin
         stage_idx_ff <= col_count_ff;
      end
   end

   assign rd_addr   = col_count_ff;
   assign stage     = stage_ff;
   assign stage_idx = stage_idx_ff;

endmodule

>>> rtl/core/lgs_window.sv
`timescale 1ns / 1ps
module lgs_window
   import lgs_pkg::*;
#(
   parameter int ADDR_WIDTH = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  stage_type             stage,
   input  logic [ADDR_WIDTH-1:0] stage_idx,
   input  logic [1:0]            rd_data,
   output logic                  wr_en,
   output logic [ADDR_WIDTH-1:0] wr_addr,
   output logic [1:0]            wr_data,
   output logic                  push,
   output result_type            push_data
);

   logic [8:0] window_ff, window_in;
   logic [2:0] column;
   logic [3:0] total, around;
   logic       centre;

   always_comb begin
      // column bits: top, middle, arriving cell
      column    = {stage.alive, rd_data[0], rd_data[1]};
      window_in = {column, window_ff[8:3]};
      total     = '0;
      for (int i = 0; i < 9; i++) begin
         total = total + 4'(window_in[i]);
      end
      centre = window_in[4];
      around = total - 4'(centre);
      if (centre) begin
         push_data.next_alive = (around == SURVIVE_MIN) || (around == SURVIVE_MAX);
      end else begin
         push_data.next_alive = (around == BIRTH_COUNT);
      end
      push_data.last_cell = stage.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (stage.valid) begin
         window_ff <= window_in;
      end
   end

   assign wr_en   = stage.valid;
   assign wr_addr = stage_idx;
   assign wr_data = {rd_data[0], stage.alive};
   assign push    = stage.valid & stage.produce;

endmodule

>>> rtl/core/lgs_out_fifo.sv
`timescale 1ns / 1ps
module lgs_out_fifo
   import lgs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  result_type               push_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output result_type               rsp_data,
   output logic [OUT_CNT_WIDTH-1:0] count
);

   result_type                 mem_ff [OUT_DEPTH];
   logic [OUT_PTR_WIDTH-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [OUT_CNT_WIDTH-1:0]   count_ff;
   logic                       pop;

   assign pop = rsp_valid & rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + OUT_PTR_WIDTH'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + OUT_PTR_WIDTH'(1);
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + OUT_CNT_WIDTH'(1);
            2'b01:   count_ff <= count_ff - OUT_CNT_WIDTH'(1);
            default: count_ff <= count_ff;
         endcase
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign count     = count_ff;

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != OUT_CNT_WIDTH'(OUT_DEPTH)) || pop)
      else $error("result queue overflow");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= OUT_CNT_WIDTH'(OUT_DEPTH))
      else $error("result queue count out of range");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == $past(count_ff) - OUT_CNT_WIDTH'(1))
      else $error("result queue count not reduced on pop");

   a_pointer_gap: assert property (@(posedge clock) disable iff (reset)
      OUT_PTR_WIDTH'(wr_ptr_ff - rd_ptr_ff) == OUT_PTR_WIDTH'(count_ff))
      else $error("result queue pointers disagree with count");
`endif

endmodule

>>> rtl/core/life_generation_stencil.sv
`timescale 1ns / 1ps
// life generation stencil, rule b3/s23
// req_ channel: one cell of the framed board per item, raster order,
//   (cols+2) x (rows+2) cells per generation; frame cells are taken as dead
// rsp_ channel: next state of each interior cell, last_cell set on the
//   final interior cell of the generation
// csr_ port: index 0 writes cols, index 1 writes rows; write only while idle
// throughput: one item per cycle while req_ready is high, set by the single line-store
//   ram read and write-back per item
// result path: the item completing a neighbourhood is registered in the scan stage and
//   the line-store read, and its result is then written into the result buffer, from which
//   the receiver can take it; the first two padded rows and columns give none
// reset: size registers return to 1599 x 959, scan counters and window clear;
//   the line store needs no clearing as the frame rows rewrite it before use
// receiver stall: results queue in a four-entry buffer; req_ready drops only
//   when the buffer and the item in flight would fill it
module life_generation_stencil
   import lgs_pkg::*;
#(
   parameter int MAX_COLS = 2048,
   parameter int MAX_ROWS = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_cell_alive,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_next_alive,
   output logic                  rsp_last_cell,
   input  logic                  csr_write_enable,
   input  logic                  csr_index,
   input  logic [COLS_WIDTH-1:0] csr_write_data
);

   localparam int DEPTH = MAX_COLS + 2;
   localparam int AW    = $clog2(DEPTH);

   logic                     accept;
   logic [AW-1:0]            rd_addr, stage_idx, wr_addr;
   stage_type                stage;
   logic [1:0]               rd_data, wr_data;
   logic                     wr_en, push;
   result_type               push_data, rsp_data;
   logic [OUT_CNT_WIDTH-1:0] count;

   assign req_ready = ({1'b0, count} + (OUT_CNT_WIDTH+1)'(stage.valid))
                      <= (OUT_CNT_WIDTH+1)'(OUT_DEPTH - 1);
   assign accept    = req_valid & req_ready;

   lgs_scan #(
      .MAX_COLS(MAX_COLS),
      .MAX_ROWS(MAX_ROWS)
   ) u_scan (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .accept          (accept),
      .cell_alive      (req_cell_alive),
      .rd_addr         (rd_addr),
      .stage           (stage),
      .stage_idx       (stage_idx)
   );

   lgs_ram #(
      .WIDTH(2),
      .DEPTH(DEPTH)
   ) u_row_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (accept),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   lgs_window #(
      .ADDR_WIDTH(AW)
   ) u_window (
      .clock    (clock),
      .reset    (reset),
      .stage    (stage),
      .stage_idx(stage_idx),
      .rd_data  (rd_data),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .push     (push),
      .push_data(push_data)
   );

   lgs_out_fifo u_out_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .count    (count)
   );

   assign rsp_next_alive = rsp_data.next_alive;
   assign rsp_last_cell  = rsp_data.last_cell;

endmodule
